// ----- rtl/hgsn_pkg.sv -----
// Package for the height-grid normal stencil: field widths, register
// indexes and defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hgsn_pkg;
	localparam int MAX_WIDTH_DEF = 32;
	localparam int POS_W = 16;
	localparam int NRM_W = 16;
	localparam int COL_W = 5;
	localparam int ROW_W = 12;
	localparam int GW_W = 6;
	localparam int GH_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;
	localparam logic [GW_W-1:0] GRID_WIDTH_RST = 6'd32;
	localparam logic [GH_W-1:0] GRID_HEIGHT_RST = 13'd32;
	localparam logic [GH_W-1:0] MAX_HEIGHT = 13'd4096;
	// Difference of two positions, and multiplier operand width.
	localparam int DIF_W = 17;
	localparam int MUL_W = 25;
	localparam int SUM_W = 36;
	localparam int MAG_W = 24;
	localparam int SQ_W = 50;
	localparam int LEN_W = 25;
	localparam int REM_W = 39;
	localparam int Q_W = 15;
	typedef logic signed [DIF_W-1:0] dif_t;
endpackage
`default_nettype wire

// ----- rtl/heightgrid_stencil_normals_core.sv -----
// Steps per normal: read, cross product, scale, squares, bit-serial square root and
// three divisions in one divider, then the output register.
// Throughput: an item with no normal every cycle while the core is idle; otherwise no new
// item is taken until all normals of the item are out. An item has one normal, or the row
// width plus one on the final vertex of a frame (the width alone for a single-row grid);
// an output stall holds the core in its output step.
// Reset: arst_n clears counters, state and output valid; registers take defaults.
// Top level of the normal stencil; depends on hgsn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module heightgrid_stencil_normals_core
	import hgsn_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic signed [POS_W-1:0] pos_z,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [NRM_W-1:0] normal_x,
	output logic signed [NRM_W-1:0] normal_y,
	output logic signed [NRM_W-1:0] normal_z,
	output logic [COL_W-1:0] column,
	output logic [ROW_W-1:0] row,
	output logic frame_last
);
	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int DEPTH = 3 * MAX_WIDTH;
	localparam int AW = $clog2(DEPTH);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_READ = 4'd1;
	localparam logic [3:0] ST_CROSS = 4'd2;
	localparam logic [3:0] ST_ABS = 4'd3;
	localparam logic [3:0] ST_SHIFT = 4'd4;
	localparam logic [3:0] ST_SQUARE = 4'd5;
	localparam logic [3:0] ST_ROOT = 4'd6;
	localparam logic [3:0] ST_DIV = 4'd7;
	localparam logic [3:0] ST_PUT = 4'd8;

	logic [3:0] state_q;
	logic [3:0] cnt_q;
	logic [GW_W-1:0] gw_q;
	logic [GH_W-1:0] gh_q;
	logic [CW-1:0] col_cnt_q;
	logic [ROW_W-1:0] row_cnt_q;
	logic [1:0] slot_cnt_q;
	logic [CW-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [1:0] cs_q;
	logic flush_q;
	logic more_q;

	logic [3*POS_W-1:0] mem [DEPTH];
	logic [3*POS_W-1:0] rd_data_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	dif_t a_q [3];
	dif_t b_q [3];
	logic signed [SUM_W-1:0] s_q [3];
	logic [SUM_W-1:0] mag_q [3];
	logic [2:0] neg_q;
	logic [MAG_W-1:0] t_q [3];
	logic signed [SQ_W-1:0] p_q;
	logic [SQ_W-1:0] sum_q;
	logic [SQ_W:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic [1:0] di_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsh_q;
	logic [Q_W-1:0] q_q;
	logic signed [NRM_W-1:0] nq_q [3];

	logic [CW-1:0] wm1;
	logic [ROW_W-1:0] hm1;
	logic accept;
	logic put_fire;
	logic [1:0] slot_sel;
	logic [CW-1:0] col_sel;
	logic [1:0] prev_s;
	logic [1:0] prev2_s;
	logic [1:0] s_idx;
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic [SUM_W-1:0] orv;
	logic [3:0] shamt;
	logic [SQ_W:0] trial;
	logic [LEN_W-1:0] len;
	logic [Q_W-1:0] q_next;
	logic q_bit;
	logic [REM_W-1:0] rem_next;
	logic [MAG_W-1:0] t_sel;

	// Effective grid size, clamped to the supported range.
	always_comb begin
		if (gw_q < GW_W'(2)) begin
			wm1 = CW'(1);
		end else if (32'(gw_q) > MAX_WIDTH) begin
			wm1 = CW'(MAX_WIDTH - 1);
		end else begin
			wm1 = CW'(gw_q - GW_W'(1));
		end
		if (gh_q == '0) begin
			hm1 = '0;
		end else if (gh_q > MAX_HEIGHT) begin
			hm1 = '1;
		end else begin
			hm1 = ROW_W'(gh_q - GH_W'(1));
		end
	end

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign put_fire = (state_q == ST_PUT) && (!out_valid || !out_stall);

	// Rows live in three slots in turn; the current input row sits in cs_q.
	assign prev_s = (cs_q == 2'd0) ? 2'd2 : cs_q - 2'd1;
	assign prev2_s = (cs_q == 2'd2) ? 2'd0 : cs_q + 2'd1;

	// Read order: top, bottom, left, right neighbor of the current vertex.
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: begin
				col_sel = col_q;
				if (flush_q) begin
					slot_sel = (row_q == '0) ? cs_q : prev_s;
				end else begin
					slot_sel = (row_q == '0) ? prev_s : prev2_s;
				end
			end
			2'd1: begin
				col_sel = col_q;
				slot_sel = cs_q;
			end
			2'd2: begin
				col_sel = (col_q == '0) ? col_q : col_q - CW'(1);
				slot_sel = flush_q ? cs_q : prev_s;
			end
			default: begin
				col_sel = (col_q == wm1) ? col_q : col_q + CW'(1);
				slot_sel = flush_q ? cs_q : prev_s;
			end
		endcase
	end

	assign rd_addr = AW'(slot_sel) * AW'(MAX_WIDTH) + AW'(col_sel);
	assign wr_addr = AW'(slot_cnt_q) * AW'(MAX_WIDTH) + AW'(col_cnt_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[wr_addr] <= {pos_x, pos_y, pos_z};
		end
		rd_data_q <= mem[rd_addr];
	end

	// Shared multiplier operand selection: cross product terms, then squares.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_CROSS) begin
			unique case (cnt_q)
				4'd0: begin mul_a = MUL_W'(a_q[1]); mul_b = MUL_W'(b_q[2]); end
				4'd1: begin mul_a = MUL_W'(a_q[2]); mul_b = MUL_W'(b_q[1]); end
				4'd2: begin mul_a = MUL_W'(a_q[2]); mul_b = MUL_W'(b_q[0]); end
				4'd3: begin mul_a = MUL_W'(a_q[0]); mul_b = MUL_W'(b_q[2]); end
				4'd4: begin mul_a = MUL_W'(a_q[0]); mul_b = MUL_W'(b_q[1]); end
				4'd5: begin mul_a = MUL_W'(a_q[1]); mul_b = MUL_W'(b_q[0]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else begin
			unique case (cnt_q[1:0])
				2'd0: t_sel = t_q[0];
				2'd1: t_sel = t_q[1];
				2'd2: t_sel = t_q[2];
				default: t_sel = '0;
			endcase
			mul_a = $signed({1'b0, t_sel});
			mul_b = $signed({1'b0, t_sel});
		end
		if (state_q == ST_CROSS) begin
			t_sel = '0;
		end
	end

	// Scale so the largest magnitude fits 24 bits.
	always_comb begin
		orv = mag_q[0] | mag_q[1] | mag_q[2];
		shamt = '0;
		for (int j = 0; j < SUM_W - MAG_W; j++) begin
			if (orv[MAG_W + j]) begin
				shamt = 4'(j + 1);
			end
		end
	end

	assign s_idx = 2'((cnt_q - 4'd1) >> 1);
	assign trial = res_q + {1'b0, bit_q};
	assign len = LEN_W'(res_q);
	assign q_bit = (rem_q >= dsh_q);
	assign rem_next = q_bit ? rem_q - dsh_q : rem_q;
	assign q_next = {q_q[Q_W-2:0], q_bit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			gw_q <= GRID_WIDTH_RST;
			gh_q <= GRID_HEIGHT_RST;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			slot_cnt_q <= '0;
			col_q <= '0;
			row_q <= '0;
			cs_q <= '0;
			flush_q <= 1'b0;
			more_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && !put_fire) begin
				out_valid <= 1'b0;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					REG_GRID_WIDTH: gw_q <= cfg_data[GW_W-1:0];
					REG_GRID_HEIGHT: gh_q <= cfg_data[GH_W-1:0];
					default: gw_q <= gw_q;
				endcase
				col_cnt_q <= '0;
				row_cnt_q <= '0;
				slot_cnt_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						cs_q <= slot_cnt_q;
						more_q <= (col_cnt_q == wm1) && (row_cnt_q == hm1);
						if (row_cnt_q != '0) begin
							col_q <= col_cnt_q;
							row_q <= row_cnt_q - ROW_W'(1);
							flush_q <= 1'b0;
							state_q <= ST_READ;
						end else if ((col_cnt_q == wm1) && (row_cnt_q == hm1)) begin
							col_q <= '0;
							row_q <= row_cnt_q;
							flush_q <= 1'b1;
							state_q <= ST_READ;
						end
						// A register write restarts the frame and wins over the advance.
						if (!cfg_write) begin
							if ((col_cnt_q == wm1) && (row_cnt_q == hm1)) begin
								col_cnt_q <= '0;
								row_cnt_q <= '0;
								slot_cnt_q <= '0;
							end else if (col_cnt_q == wm1) begin
								col_cnt_q <= '0;
								row_cnt_q <= row_cnt_q + ROW_W'(1);
								slot_cnt_q <= (slot_cnt_q == 2'd2) ? 2'd0
									: slot_cnt_q + 2'd1;
							end else begin
								col_cnt_q <= col_cnt_q + CW'(1);
							end
						end
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd4) begin
						cnt_q <= '0;
						state_q <= ST_CROSS;
					end
				end
				ST_CROSS: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd6) begin
						cnt_q <= '0;
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					cnt_q <= '0;
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd3) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (bit_q == SQ_W'(1)) begin
						cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(Q_W)) begin
						cnt_q <= '0;
						if (di_q == 2'd2) begin
							state_q <= ST_PUT;
						end
					end
				end
				ST_PUT: begin
					if (put_fire) begin
						out_valid <= 1'b1;
						cnt_q <= '0;
						if (flush_q) begin
							if (col_q == wm1) begin
								state_q <= ST_IDLE;
							end else begin
								col_q <= col_q + CW'(1);
								state_q <= ST_READ;
							end
						end else if (more_q) begin
							flush_q <= 1'b1;
							col_q <= '0;
							row_q <= row_q + ROW_W'(1);
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers; the sequencer above decides which step runs.
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		unique case (state_q)
			ST_READ: begin
				// Differences T-B and L-R give the summed fan cross product directly.
				if (cnt_q == 4'd1 || cnt_q == 4'd3) begin
					a_q[0] <= (cnt_q == 4'd1) ? DIF_W'($signed(rd_data_q[47:32])) : a_q[0];
					a_q[1] <= (cnt_q == 4'd1) ? DIF_W'($signed(rd_data_q[31:16])) : a_q[1];
					a_q[2] <= (cnt_q == 4'd1) ? DIF_W'($signed(rd_data_q[15:0])) : a_q[2];
					b_q[0] <= (cnt_q == 4'd3) ? DIF_W'($signed(rd_data_q[47:32])) : b_q[0];
					b_q[1] <= (cnt_q == 4'd3) ? DIF_W'($signed(rd_data_q[31:16])) : b_q[1];
					b_q[2] <= (cnt_q == 4'd3) ? DIF_W'($signed(rd_data_q[15:0])) : b_q[2];
				end else if (cnt_q == 4'd2) begin
					a_q[0] <= a_q[0] - DIF_W'($signed(rd_data_q[47:32]));
					a_q[1] <= a_q[1] - DIF_W'($signed(rd_data_q[31:16]));
					a_q[2] <= a_q[2] - DIF_W'($signed(rd_data_q[15:0]));
				end else if (cnt_q == 4'd4) begin
					b_q[0] <= b_q[0] - DIF_W'($signed(rd_data_q[47:32]));
					b_q[1] <= b_q[1] - DIF_W'($signed(rd_data_q[31:16]));
					b_q[2] <= b_q[2] - DIF_W'($signed(rd_data_q[15:0]));
				end
				s_q[0] <= '0;
				s_q[1] <= '0;
				s_q[2] <= '0;
			end
			ST_CROSS: begin
				if (cnt_q != 4'd0) begin
					if (cnt_q[0]) begin
						s_q[s_idx] <= s_q[s_idx] + SUM_W'(p_q);
					end else begin
						s_q[s_idx] <= s_q[s_idx] - SUM_W'(p_q);
					end
				end
			end
			ST_ABS: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= s_q[i][SUM_W-1];
					mag_q[i] <= s_q[i][SUM_W-1] ? SUM_W'(-s_q[i]) : SUM_W'(s_q[i]);
				end
			end
			ST_SHIFT: begin
				for (int i = 0; i < 3; i++) begin
					t_q[i] <= MAG_W'(mag_q[i] >> shamt);
				end
				sum_q <= '0;
			end
			ST_SQUARE: begin
				if (cnt_q != 4'd0) begin
					sum_q <= sum_q + SQ_W'(p_q);
				end
				res_q <= '0;
				bit_q <= SQ_W'(1) << (SQ_W - 2);
			end
			ST_ROOT: begin
				if ({1'b0, sum_q} >= trial) begin
					sum_q <= sum_q - SQ_W'(trial);
					res_q <= (res_q >> 1) + {1'b0, bit_q};
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				di_q <= '0;
			end
			ST_DIV: begin
				if (cnt_q == 4'd0) begin
					rem_q <= REM_W'({t_q[di_q], 14'd0}) + REM_W'(len >> 1);
					dsh_q <= REM_W'({len, 14'd0});
					q_q <= '0;
				end else begin
					rem_q <= rem_next;
					dsh_q <= dsh_q >> 1;
					q_q <= q_next;
					if (cnt_q == 4'(Q_W)) begin
						if (len == '0) begin
							nq_q[di_q] <= '0;
						end else if (neg_q[di_q]) begin
							nq_q[di_q] <= -$signed(NRM_W'(q_next));
						end else begin
							nq_q[di_q] <= $signed(NRM_W'(q_next));
						end
						di_q <= di_q + 2'd1;
					end
				end
			end
			ST_PUT: begin
				if (!out_valid || !out_stall) begin
					normal_x <= nq_q[0];
					normal_y <= nq_q[1];
					normal_z <= nq_q[2];
					column <= COL_W'(col_q);
					row <= row_q;
					frame_last <= flush_q && (col_q == wm1);
				end
			end
			default: begin
				di_q <= di_q;
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the height-grid vertex normal stencil.
// Drives vertex transfers and grid registers, predicts normals in a scoreboard class.
// Depends on hgsn_pkg and heightgrid_stencil_normals_core.
`timescale 1ns / 1ps

typedef struct packed {
	logic [15:0] nx;
	logic [15:0] ny;
	logic [15:0] nz;
	logic [4:0]  col;
	logic [11:0] rw;
	logic        last;
} normal_rec_t;

class stencil_normals;
	logic signed [15:0] grid_store [96][3];
	int unsigned next_col;
	int unsigned next_row;
	logic [5:0]  width_reg;
	logic [12:0] height_reg;
	normal_rec_t pending_normals [$];
	int errors;
	int normals_seen;

	function new();
		next_col = 0;
		next_row = 0;
		width_reg = hgsn_pkg::GRID_WIDTH_RST;
		height_reg = hgsn_pkg::GRID_HEIGHT_RST;
		errors = 0;
		normals_seen = 0;
	endfunction

	function int unsigned used_width();
		if (width_reg < 2) return 2;
		if (width_reg > 32) return 32;
		return width_reg;
	endfunction

	function int unsigned used_height();
		if (height_reg < 1) return 1;
		if (height_reg > 4096) return 4096;
		return height_reg;
	endfunction

	function void write_reg(logic [hgsn_pkg::CFG_IDX_W-1:0] idx,
			logic [hgsn_pkg::CFG_DATA_W-1:0] data);
		if (idx == hgsn_pkg::REG_GRID_WIDTH) width_reg = data[5:0];
		else height_reg = data[12:0];
		next_col = 0;
		next_row = 0;
	endfunction

	function longint coord(int c, int r, int a);
		int unsigned w;
		int unsigned h;
		w = used_width();
		h = used_height();
		if (c < 0) c = 0;
		if (c >= int'(w)) c = w - 1;
		if (r < 0) r = 0;
		if (r >= int'(h)) r = h - 1;
		return longint'(grid_store[(r % 3) * 32 + c][a]);
	endfunction

	// Adds the cross product (a - ctr) x (b - ctr) of one triangle to the sum.
	function void add_triangle(inout longint s [3], input int cc, input int cr,
			input int ac, input int ar, input int bc, input int br);
		longint u [3];
		longint v [3];
		for (int i = 0; i < 3; i++) begin
			u[i] = coord(ac, ar, i) - coord(cc, cr, i);
			v[i] = coord(bc, br, i) - coord(cc, cr, i);
		end
		s[0] += u[1] * v[2] - u[2] * v[1];
		s[1] += u[2] * v[0] - u[0] * v[2];
		s[2] += u[0] * v[1] - u[1] * v[0];
	endfunction

	function longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function void predict_normal(int c, int r, bit last);
		longint s [3];
		longint unsigned mag [3];
		longint unsigned m;
		longint unsigned sq;
		longint unsigned len;
		longint unsigned q;
		logic [15:0] comp [3];
		int k;
		normal_rec_t rec;
		s = '{0, 0, 0};
		add_triangle(s, c, r, c, r - 1, c - 1, r);
		add_triangle(s, c, r, c + 1, r, c, r - 1);
		add_triangle(s, c, r, c, r + 1, c + 1, r);
		add_triangle(s, c, r, c - 1, r, c, r + 1);
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = s[i] < 0 ? longint'(-s[i]) : longint'(s[i]);
			if (mag[i] > m) m = mag[i];
		end
		k = 0;
		while ((m >> k) >= (64'd1 << 24)) k++;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] >>= k;
			sq += mag[i] * mag[i];
		end
		len = int_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q = 0;
			if (len != 0) q = (mag[i] * 16384 + (len >> 1)) / len;
			if (s[i] < 0) q = -q;
			comp[i] = q[15:0];
		end
		rec.nx = comp[0];
		rec.ny = comp[1];
		rec.nz = comp[2];
		rec.col = c[4:0];
		rec.rw = r[11:0];
		rec.last = last;
		pending_normals = {pending_normals, rec};
	endfunction

	function void take_vertex(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] pz);
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;
		w = used_width();
		h = used_height();
		x = next_col;
		y = next_row;
		if (x >= w) x = w - 1;
		if (y >= h) y = h - 1;
		grid_store[(y % 3) * 32 + x][0] = px;
		grid_store[(y % 3) * 32 + x][1] = py;
		grid_store[(y % 3) * 32 + x][2] = pz;
		if (y >= 1) predict_normal(x, y - 1, 0);
		if (x == w - 1 && y == h - 1) begin
			// Last vertex of the frame flushes the bottom row.
			for (int c = 0; c < int'(w); c++) predict_normal(c, y, c == w - 1);
			next_col = 0;
			next_row = 0;
		end else begin
			x++;
			if (x == w) begin
				x = 0;
				y++;
			end
			next_col = x;
			next_row = y;
		end
	endfunction

	function void match_normal(normal_rec_t got);
		normal_rec_t want;
		normals_seen++;
		if (pending_normals.size() == 0) begin
			$display("%0t: unexpected normal col %0d row %0d", $time, got.col, got.rw);
			errors++;
			return;
		end
		want = pending_normals.pop_front();
		if (got !== want) begin
			$display("%0t: mismatch expected n=(%h %h %h) col %0d row %0d last %0d",
				$time, want.nx, want.ny, want.nz, want.col, want.rw, want.last);
			$display("%0t:          actual   n=(%h %h %h) col %0d row %0d last %0d",
				$time, got.nx, got.ny, got.nz, got.col, got.rw, got.last);
			errors++;
		end
	endfunction
endclass

module testbench;
	import hgsn_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic out_valid;
	logic out_stall;
	logic signed [NRM_W-1:0] normal_x;
	logic signed [NRM_W-1:0] normal_y;
	logic signed [NRM_W-1:0] normal_z;
	logic [COL_W-1:0] column;
	logic [ROW_W-1:0] row;
	logic frame_last;

	stencil_normals board;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	int vertices_sent;
	int frames_done;

	heightgrid_stencil_normals_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.column(column), .row(row), .frame_last(frame_last)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("status: fail");
		$finish;
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1;
				hold_cycles--;
			end else begin
				out_stall <= ($urandom % 100) < recv_idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		normal_rec_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.nx = normal_x;
			got.ny = normal_y;
			got.nz = normal_z;
			got.col = column;
			got.rw = row;
			got.last = frame_last;
			board.match_normal(got);
		end
	end

	task automatic send_vertex(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
		@(negedge clk);
		while (($urandom % 100) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		do @(posedge clk); while (in_stall);
		board.take_vertex(px, py, pz);
		vertices_sent++;
		if (vertices_sent == 150) hold_cycles = 3000;
		if (vertices_sent == 130) begin
			send_idle_pct = 45;
			recv_idle_pct = 28;
		end else if (vertices_sent == 260) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (board.pending_normals.size() != 0) @(posedge clk);
		// Items without results may still be in flight.
		repeat (200) @(posedge clk);
	endtask

	task automatic write_grid(logic [5:0] w_raw, logic [12:0] h_raw);
		drain();
		@(negedge clk);
		cfg_write <= 1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= CFG_DATA_W'(w_raw);
		@(posedge clk);
		board.write_reg(REG_GRID_WIDTH, CFG_DATA_W'(w_raw));
		@(negedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data <= h_raw;
		@(posedge clk);
		board.write_reg(REG_GRID_HEIGHT, h_raw);
		@(negedge clk);
		cfg_write <= 0;
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom % 5)
			0: return 16'($urandom);
			1: return ($urandom % 2) ? 16'h7fff : 16'h8000;
			2: return 16'($urandom_range(0, 2047)) - 16'd1024;
			default: return 16'($urandom_range(0, 8191)) - 16'd4096;
		endcase
	endfunction

	task automatic random_vertices(int n);
		for (int i = 0; i < n; i++) send_vertex(rand_coord(), rand_coord(), rand_coord());
	endtask

	initial begin
		int w_raw;
		int h_raw;
		int wu;
		int hu;
		int n;
		board = new();
		arst_n = 0;
		cfg_write = 0;
		cfg_index = REG_GRID_WIDTH;
		cfg_data = 0;
		in_valid = 0;
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;
		send_idle_pct = 28;
		recv_idle_pct = 45;
		hold_cycles = 0;
		vertices_sent = 0;
		frames_done = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Reset geometry: a partial 32-wide frame, then restart by register write.
		random_vertices(40);

		// Out-of-range zero values clamp to a 2x1 grid: only flushes occur.
		write_grid(6'd0, 13'd0);
		send_vertex(16'h0000, 16'h0000, 16'h0000);
		send_vertex(16'h0000, 16'h0000, 16'h0000);
		send_vertex(16'h7fff, 16'h8000, 16'h7fff);
		send_vertex(16'h8000, 16'h7fff, 16'h8000);
		send_vertex(16'h8000, 16'h8000, 16'h8000);
		send_vertex(16'h7fff, 16'h7fff, 16'h7fff);

		// 3x3 grid with heights at the extremes.
		write_grid(6'd3, 13'd3);
		for (int i = 0; i < 9; i++)
			send_vertex(16'((i % 3) * 256), (i % 2) ? 16'h7fff : 16'h8000, 16'((i / 3) * 256));

		// Width of one clamps up to two, two rows.
		write_grid(6'd1, 13'd2);
		send_vertex(16'h8000, 16'h7fff, 16'h7fff);
		send_vertex(16'h7fff, 16'h8000, 16'h8000);
		send_vertex(16'h7fff, 16'h7fff, 16'h8000);
		send_vertex(16'h8000, 16'h8000, 16'h7fff);

		// Largest raw values: clamped to 32 wide, 4096 rows, fed partially.
		write_grid(6'd63, 13'd8191);
		random_vertices(96);

		write_grid(6'd32, 13'd2);
		random_vertices(64);
		frames_done = 5;

		while (vertices_sent < 350) begin
			w_raw = ($urandom % 10 < 7) ? $urandom_range(2, 6) : $urandom_range(0, 63);
			case ($urandom % 10)
				0: h_raw = 0;
				1: h_raw = ($urandom % 2) ? 4096 : $urandom_range(4097, 8191);
				default: h_raw = $urandom_range(1, 5);
			endcase
			write_grid(w_raw[5:0], h_raw[12:0]);
			wu = board.used_width();
			hu = board.used_height();
			if (hu > 8) n = wu * $urandom_range(2, 3);
			else if ($urandom % 5 == 0) n = $urandom_range(1, wu * hu);
			else n = wu * hu;
			random_vertices(n);
			frames_done++;
		end

		drain();
		$display("Covered %0d vertex transfers over %0d grid settings, %0d normals checked,",
			vertices_sent, frames_done, board.normals_seen);
		$display("including clamped registers, flat grids, extreme positions and a long stall.");
		if (board.errors == 0 && board.pending_normals.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/hgsn_pkg.sv
rtl/heightgrid_stencil_normals_core.sv
dv/testbench.sv
